FILE: rtl/tst_pkg.sv
// shared types and constants for the traffic stream table
`default_nettype none
package tst_pkg;
  localparam int unsigned PeerW = 48;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RM_PEER = 2'd1,
    OP_RM_ALL  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_MCAST     = 3'd2,
    ST_BAD_TID   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam logic [2:0] PrioTid0 = 3'd0;
  localparam logic [2:0] PrioTid1 = 3'd2;
  localparam logic [2:0] PrioTid4 = 3'd5;
  localparam logic [2:0] PrioTid6 = 3'd7;

  localparam logic [1:0] RegQos = 2'd0;

  // tid to priority mapping, bit 3 flags an invalid tid
  function automatic logic [3:0] tid_map(input logic [3:0] tid);
    logic [3:0] r;
    case (tid)
      4'd0, 4'd3: r = {1'b0, PrioTid0};
      4'd1, 4'd2: r = {1'b0, PrioTid1};
      4'd4, 4'd5: r = {1'b0, PrioTid4};
      4'd6, 4'd7: r = {1'b0, PrioTid6};
      default:    r = 4'b1000;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tst_req_if.sv
// request and result stream interfaces
`default_nettype none
interface tst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [47:0] peer_addr;
  logic [3:0]  tid;
  logic        is_tx;
  logic        add_if_missing;
  modport source (output valid, op, peer_addr, tid, is_tx, add_if_missing, input ready);
  modport sink   (input valid, op, peer_addr, tid, is_tx, add_if_missing, output ready);
endinterface

interface tst_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] entry_index;
  logic [5:0] removed_count;
  modport source (output valid, status, entry_index, removed_count, input ready);
  modport sink   (input valid, status, entry_index, removed_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/traffic_stream_table_top.sv
// top level of the traffic stream table
//  channel | dir | signals
//  req     | in  | op, peer_addr, tid, is_tx, add_if_missing
//  rsp     | out | status, entry_index, removed_count
//  apb     | in  | qos_enabled at address 0
// a get walks the admitted entries one per cycle
// a remove walks both tables one entry per cycle
// one item at a time; synchronous reset restores empty tables at once
// a held result stalls the next request until taken
`default_nettype none
module traffic_stream_table_top
  import tst_pkg::*;
#(
  parameter int unsigned STREAM_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tst_req_if.sink   req,
  tst_rsp_if.source rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic qos, load, step, side, wr_back, walk_last, hit;

  assign pready = 1'b1;
  assign prdata = {31'd0, qos};
  // qos register write
  always_ff @(posedge clk) begin
    if (rst) qos <= 1'b0;
    else if (psel && penable && pwrite && paddr == {RegQos}) qos <= pwdata[0];
  end

  tst_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .in_op(req.op),
    .walk_last, .hit, .load, .step, .side, .wr_back
  );

  tst_dp #(.N(STREAM_ENTRIES)) u_dp (
    .clk, .rst, .qos, .load, .step, .side, .wr_back,
    .op(req.op), .peer_addr(req.peer_addr), .tid(req.tid), .is_tx(req.is_tx),
    .add_if_missing(req.add_if_missing), .walk_last, .hit,
    .status(rsp.status), .entry_index(rsp.entry_index),
    .removed_count(rsp.removed_count)
  );
endmodule
`default_nettype wire

FILE: rtl/tst_ctrl.sv
// controller: sequences searches, allocation and removal walks
`default_nettype none
module tst_ctrl
  import tst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire logic [1:0] in_op,
  input  wire logic       walk_last,
  input  wire logic       hit,
  output logic      load,
  output logic      step,
  output logic      side,
  output logic      wr_back
);
  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_RM, S_DONE} state_t;
  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign load       = in_valid && in_ready;
  assign step       = (state == S_SRCH) || (state == S_RM);
  assign wr_back    = (state == S_SRCH) && (walk_last || hit);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      side      <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (load) begin
            side  <= 1'b1;
            if (in_op == OP_RM_PEER || in_op == OP_RM_ALL) state <= S_RM;
            else if (in_op == OP_GET) state <= S_SRCH;
            else begin
              state     <= S_DONE;
              out_valid <= 1'b1;
            end
          end
        end
        S_SRCH: begin
          if (walk_last || hit) begin
            state     <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        S_RM: begin
          if (walk_last) begin
            if (side) side <= 1'b0;
            else begin
              state     <= S_DONE;
              out_valid <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tst_dp.sv
// datapath: entry tables, admission order, free queues and walk counter
`default_nettype none
module tst_dp
  import tst_pkg::*;
#(
  parameter int unsigned N = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic qos,
  input  wire logic load,
  input  wire logic step,
  input  wire logic side,
  input  wire logic wr_back,
  input  wire logic [1:0]  op,
  input  wire logic [47:0] peer_addr,
  input  wire logic [3:0]  tid,
  input  wire logic        is_tx,
  input  wire logic        add_if_missing,
  output logic             walk_last,
  output logic             hit,
  output logic [2:0]       status,
  output logic [3:0]       entry_index,
  output logic [5:0]       removed_count
);
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);

  logic            valid_q [2][N];
  logic [47:0]     peer_q  [2][N];
  logic [2:0]      prio_q  [2][N];
  logic [IW-1:0]   order_q [2][N];
  logic [CW-1:0]   acnt    [2];
  logic [IW-1:0]   fq      [2][N];
  logic [IW-1:0]   fhead   [2];
  logic [CW-1:0]   fcnt    [2];

  // captured request
  logic [1:0]  op_r;
  logic [47:0] peer_r;
  logic [2:0]  prio_r;
  logic        tbl_r, add_r, early;
  logic [CW-1:0] k, kept;
  logic [5:0]  freed;
  logic        tb;
  logic [IW-1:0] idx, pos, alloc, fhead_inc;
  logic [CW:0] pos_sum;
  logic        match, dorm;
  logic [3:0]  tm;

  assign tm    = tid_map(tid);
  assign tb    = (op_r == OP_GET) ? tbl_r : side;
  assign idx   = order_q[tb][k[IW-1:0]];
  assign walk_last = early || (k >= acnt[tb]) || (k + CW'(1) >= acnt[tb]);
  assign match = (k < acnt[tb]) && valid_q[tb][idx] && peer_q[tb][idx] == peer_r
                 && prio_q[tb][idx] == prio_r;
  assign hit   = (op_r == OP_GET) && !early && match;
  assign dorm  = (k < acnt[tb]) && ((op_r == OP_RM_ALL) || peer_q[tb][idx] == peer_r);
  // free queue tail and head advance, wrapped at the table size
  assign pos_sum   = (CW+1)'(fhead[tb]) + (CW+1)'(fcnt[tb]);
  assign pos       = (pos_sum >= (CW+1)'(N)) ? IW'(pos_sum - (CW+1)'(N)) : IW'(pos_sum);
  assign fhead_inc = (fhead[tb] == IW'(N - 1)) ? '0 : fhead[tb] + IW'(1);
  assign alloc = fq[tb][fhead[tb]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < 2; t++) begin
        for (int i = 0; i < N; i++) begin
          valid_q[t][i] <= 1'b0;
          peer_q[t][i]  <= '0;
          prio_q[t][i]  <= '0;
          fq[t][i]      <= IW'(i);
        end
        acnt[t]  <= '0;
        fhead[t] <= '0;
        fcnt[t]  <= CW'(N);
      end
    end else if (load) begin
      op_r   <= op;
      peer_r <= peer_addr;
      tbl_r  <= is_tx;
      add_r  <= add_if_missing;
      prio_r <= qos ? tm[2:0] : 3'd0;
      k <= '0; kept <= '0; freed <= '0;
      entry_index <= '0; removed_count <= '0;
      early <= 1'b0;
      status <= ST_NOT_FOUND;
      if (op == OP_GET) begin
        if (peer_addr[40]) begin
          status <= ST_MCAST; early <= 1'b1;
        end else if (qos && tm[3]) begin
          status <= ST_BAD_TID; early <= 1'b1;
        end
      end else if (op != OP_NONE) begin
        status <= ST_FOUND;
      end
    end else if (step) begin
      // one admitted entry per cycle
      if (op_r == OP_GET) begin
        k <= k + CW'(1);
        if (hit) begin
          status <= ST_FOUND; entry_index <= 4'(idx);
        end else if (wr_back && !early) begin
          if (!add_r) status <= ST_NOT_FOUND;
          else if (fcnt[tb] == '0 || acnt[tb] >= CW'(N)) status <= ST_FULL;
          else begin
            status <= ST_CREATED;
            entry_index <= 4'(alloc);
            valid_q[tb][alloc] <= 1'b1;
            peer_q[tb][alloc]  <= peer_r;
            prio_q[tb][alloc]  <= prio_r;
            order_q[tb][acnt[tb][IW-1:0]] <= alloc;
            acnt[tb]  <= acnt[tb] + CW'(1);
            fhead[tb] <= fhead_inc;
            fcnt[tb]  <= fcnt[tb] - CW'(1);
          end
        end
      end else begin
        k <= walk_last ? '0 : k + CW'(1);
        if (dorm) begin
          valid_q[tb][idx] <= 1'b0;
          fq[tb][pos]      <= idx;
          fcnt[tb]         <= fcnt[tb] + CW'(1);
          freed            <= freed + 6'd1;
          removed_count    <= freed + 6'd1;
        end else if (k < acnt[tb]) begin
          order_q[tb][kept[IW-1:0]] <= idx;
        end
        if (walk_last) begin
          acnt[tb] <= (k < acnt[tb] && !dorm) ? kept + CW'(1) : kept;
          kept <= '0;
        end else if (k < acnt[tb] && !dorm) begin
          kept <= kept + CW'(1);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tst_checker.sv
// port-level checks for the traffic stream table
`default_nettype none
module tst_checker
  import tst_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] status
);
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result held");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL) else $error("status code out of range");
endmodule

bind traffic_stream_table_top tst_checker u_chk (
  .clk, .rst, .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .status(rsp.status)
);
`default_nettype wire

FILE: bench/tb_traffic_stream_table_top.sv
// testbench for the traffic stream table: queued driver, monitor and table predictor
`default_nettype none
module tb_traffic_stream_table_top;
  import tst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = 16;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    op_t         op;
    logic [47:0] peer;
    logic [3:0]  tid;
    logic        is_tx;
    logic        add;
  } request_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] index;
    logic [5:0] removed;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic req_fire = 1'b0;

  tst_req_if req ();
  tst_rsp_if rsp ();

  traffic_stream_table_top #(.STREAM_ENTRIES(Entries)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic        qos_on;
  logic        ent_valid [2][Entries];
  logic [47:0] ent_peer [2][Entries];
  logic [2:0]  ent_prio [2][Entries];
  logic [3:0]  order [2][Entries];
  int          order_len [2];
  logic [3:0]  free_ring [2][Entries];
  int          ring_head [2];
  int          ring_len [2];

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  logic [47:0] peer_pool [8];

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic reset_tables();
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < Entries; i++) begin
        ent_valid[t][i] = 1'b0;
        ent_peer[t][i] = '0;
        ent_prio[t][i] = '0;
        order[t][i] = '0;
        free_ring[t][i] = 4'(i);
      end
      order_len[t] = 0;
      ring_head[t] = 0;
      ring_len[t] = Entries;
    end
    qos_on = 1'b0;
  endtask

  // frees matching entries of one table in admission order
  function automatic int purge_table(int t, bit all, logic [47:0] peer);
    int kept;
    int freed;
    logic [3:0] idx;
    kept = 0;
    freed = 0;
    for (int k = 0; k < order_len[t]; k++) begin
      idx = order[t][k];
      if (all || ent_peer[t][idx] == peer) begin
        ent_valid[t][idx] = 1'b0;
        free_ring[t][(ring_head[t] + ring_len[t]) % Entries] = idx;
        ring_len[t]++;
        freed++;
      end else begin
        order[t][kept] = idx;
        kept++;
      end
    end
    order_len[t] = kept;
    return freed;
  endfunction

  function automatic outcome_t lookup_stream(request_t r);
    outcome_t o;
    logic [2:0] prio;
    bit bad;
    bit hit;
    int t;
    logic [3:0] idx;
    o.status = ST_NOT_FOUND;
    o.index = '0;
    o.removed = '0;
    prio = '0;
    bad = 0;
    hit = 0;
    t = r.is_tx;
    if (r.op == OP_RM_PEER || r.op == OP_RM_ALL) begin
      o.removed = 6'(purge_table(1, r.op == OP_RM_ALL, r.peer)
                  + purge_table(0, r.op == OP_RM_ALL, r.peer));
      o.status = ST_FOUND;
    end else if (r.op == OP_GET) begin
      if (qos_on) begin
        case (r.tid)
          4'd0, 4'd3: prio = 3'd0;
          4'd1, 4'd2: prio = 3'd2;
          4'd4, 4'd5: prio = 3'd5;
          4'd6, 4'd7: prio = 3'd7;
          default: bad = 1;
        endcase
      end
      if (r.peer[40]) begin
        o.status = ST_MCAST;
      end else if (bad) begin
        o.status = ST_BAD_TID;
      end else begin
        for (int k = 0; k < order_len[t] && !hit; k++) begin
          idx = order[t][k];
          if (ent_valid[t][idx] && ent_peer[t][idx] == r.peer && ent_prio[t][idx] == prio) begin
            hit = 1;
            o.index = idx;
          end
        end
        if (hit) begin
          o.status = ST_FOUND;
        end else if (!r.add) begin
          o.status = ST_NOT_FOUND;
        end else if (ring_len[t] == 0 || order_len[t] >= Entries) begin
          o.status = ST_FULL;
        end else begin
          idx = free_ring[t][ring_head[t]];
          ring_head[t] = (ring_head[t] + 1) % Entries;
          ring_len[t]--;
          ent_valid[t][idx] = 1'b1;
          ent_peer[t][idx] = r.peer;
          ent_prio[t][idx] = prio;
          order[t][order_len[t]] = idx;
          order_len[t]++;
          o.index = idx;
          o.status = ST_CREATED;
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // request driver: one beat per handshake, changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_fire) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        {req.op, req.peer_addr, req.tid, req.is_tx, req.add_if_missing} <= pending_reqs[0];
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // pop the accepted beat and predict it
  always @(posedge clk) begin
    req_fire <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      expected_outcomes.push_back(lookup_stream(pending_reqs.pop_front()));
    end
  end

  // result receiver with random stalls and a long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result, status", rsp.status, -1);
      end else begin
        w = expected_outcomes.pop_front();
        if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
        if (rsp.entry_index !== w.index) report_mismatch("entry_index", rsp.entry_index, w.index);
        if (rsp.removed_count !== w.removed)
          report_mismatch("removed_count", rsp.removed_count, w.removed);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_traffic_stream_table_top NOT OK");
        $finish;
      end
    end
  end

  task automatic write_qos(logic value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegQos;
    pwdata <= {31'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    qos_on = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic request_t make_req(op_t op, logic [47:0] peer, logic [3:0] tid,
                                        logic is_tx, logic add);
    request_t r;
    r.op = op;
    r.peer = peer;
    r.tid = tid;
    r.is_tx = is_tx;
    r.add = add;
    return r;
  endfunction

  // mostly pooled unicast peers, sometimes fully random
  function automatic request_t random_req();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.peer = peer_pool[$urandom_range(7)];
    if ($urandom_range(9) == 0) r.peer = 48'({$urandom, $urandom});
    r.tid = 4'($urandom);
    if ($urandom_range(3) != 0) r.tid[3] = 1'b0;
    r.is_tx = 1'($urandom);
    r.add = ($urandom_range(3) != 0);
    if (pick < 80) r.op = OP_GET;
    else if (pick < 92) r.op = OP_RM_PEER;
    else if (pick < 97) r.op = OP_RM_ALL;
    else r.op = OP_NONE;
    return r;
  endfunction

  initial begin
    req.valid = 1'b0;
    req.op = OP_GET;
    req.peer_addr = '0;
    req.tid = '0;
    req.is_tx = 1'b0;
    req.add_if_missing = 1'b0;
    rsp.ready = 1'b0;
    reset_tables();
    for (int i = 0; i < 8; i++) begin
      peer_pool[i] = 48'({$urandom, $urandom});
      peer_pool[i][40] = 1'b0;
    end
    peer_pool[0] = '0;
    peer_pool[1] = 48'hFEFF_FFFF_FFFF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every status but bad tid, fill one table to full
    pending_reqs.push_back(make_req(OP_GET, 48'h0, 4'd15, 1'b1, 1'b0));
    pending_reqs.push_back(make_req(OP_GET, 48'h0, 4'd15, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_GET, 48'h0, 4'd9, 1'b1, 1'b0));
    pending_reqs.push_back(make_req(OP_GET, 48'hFFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(OP_NONE, 48'hFFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1));
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(make_req(OP_GET, 48'(i * 2), 4'd0, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(OP_RM_PEER, 48'd4, 4'd0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(OP_RM_ALL, 48'h0100_0000_0000, 4'd0, 1'b0, 1'b0));
    drain();

    // qos on: every tid, multicast precedence, remove-all
    write_qos(1'b1);
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(make_req(OP_GET, peer_pool[1], 4'(i), 1'(i), 1'b1));
    pending_reqs.push_back(make_req(OP_GET, 48'h0100_0000_0000, 4'd12, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(OP_RM_ALL, 48'h0, 4'd0, 1'b0, 1'b0));
    drain();

    // random phases with different idling mixes and qos settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      write_qos(1'(ph % 2));
      for (int i = 0; i < 210; i++) pending_reqs.push_back(random_req());
      if (ph == 4) begin
        @(negedge clk);
        hold_cycles = 400;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_traffic_stream_table_top OK");
    end else begin
      $display("tb_traffic_stream_table_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/tst_pkg.sv
rtl/tst_req_if.sv
rtl/tst_ctrl.sv
rtl/tst_dp.sv
rtl/traffic_stream_table_top.sv
rtl/tst_checker.sv
bench/tb_traffic_stream_table_top.sv
